/* rtl/sorted_limit_order_book_unit_macros.svh */
// Assertion macros used by the checker file.
`ifndef SORTED_LIMIT_ORDER_BOOK_UNIT_MACROS_SVH
`define SORTED_LIMIT_ORDER_BOOK_UNIT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define SLOB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that also holds while reset is asserted.
`define SLOB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/slob_pkg.sv */
`timescale 1ns / 1ps
package slob_pkg;

   localparam int unsigned DEPTH     = 32;
   localparam int unsigned IDX_W     = $clog2(DEPTH);
   localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
   localparam int unsigned ADDR_W    = IDX_W + 1;
   localparam int unsigned RAM_DEPTH = 2 * DEPTH;
   localparam int unsigned ENTRY_W   = 96;
   localparam int unsigned TDATA_W   = 104;
   localparam int unsigned CSR_AW    = 3;

   localparam logic [2:0] REQ_CREATE   = 3'd0;
   localparam logic [2:0] REQ_UPDATE   = 3'd1;
   localparam logic [2:0] REQ_REMOVE   = 3'd2;
   localparam logic [2:0] REQ_DUMP_BID = 3'd3;
   localparam logic [2:0] REQ_DUMP_ASK = 3'd4;

   localparam logic [CSR_AW-1:0] CSR_SILENT_ADDR = 3'd0;

   localparam logic STATUS_ENTRY = 1'b0;
   localparam logic STATUS_FULL  = 1'b1;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] price;
      logic [31:0] qty;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISP,
      ST_REJ,
      ST_C_RD,
      ST_C_EX,
      ST_F_RD,
      ST_F_EX,
      ST_U_UP_RD,
      ST_U_UP_EX,
      ST_U_DN_RD,
      ST_U_DN_EX,
      ST_R_RD,
      ST_R_EX,
      ST_DP_RD,
      ST_DP_EX
   } state_type;

endpackage

/* rtl/slob_ram.sv */
`timescale 1ns / 1ps
module slob_ram #(
   parameter int unsigned WIDTH = 96,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/slob_cmp.sv */
`timescale 1ns / 1ps
// Ordering unit: true when entry a must stand strictly ahead of entry b.
module slob_cmp (
   input  slob_pkg::entry_type a,
   input  slob_pkg::entry_type b,
   input  logic                desc,
   output logic                ahead
);

   always_comb begin
      if (desc) begin
         ahead = (a.price > b.price) || ((a.price == b.price) && (a.qty > b.qty));
      end else begin
         ahead = (a.price < b.price) || ((a.price == b.price) && (a.qty < b.qty));
      end
   end

endmodule

/* rtl/sorted_limit_order_book_unit.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// req_      in         tvalid/tready          tuser: kind, tdata: order fields
// rsp_      out        tvalid/tready/tlast    tuser: status, tdata: entry fields
// csr_      in         psel/penable/pready    silent_mode at byte address 0
//
// One request is worked on at a time; the block is not ready until it ends.
// Every step of the sequencer has a read state on the shared entry memory and
// an execute state that compares through the single ordering unit or moves or
// sends the entry read. A create shifts entries toward the tail until the order
// reaches its place, an update or remove searches both sides, and a dump sends
// one listed entry per step.
// Reset is synchronous and clears counts, id counter and control; the entry
// memory is not cleared. A stalled response holds the sequencer in place.
module sorted_limit_order_book_unit (
   input  logic                         clock,
   input  logic                         reset,
   // req_tdata: side[0], price[32:1], quantity[64:33], target_id[96:65]
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [slob_pkg::TDATA_W-1:0] req_tdata,
   // req_tuser: req_type[2:0]
   input  logic [2:0]                   req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // rsp_tdata: entry_id[31:0], out_side[32], out_price[64:33],
   // out_quantity[96:65]
   output logic [slob_pkg::TDATA_W-1:0] rsp_tdata,
   // rsp_tuser: out_status[0]
   output logic [0:0]                   rsp_tuser,
   output logic                         rsp_tlast,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [slob_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   localparam int unsigned IW = slob_pkg::IDX_W;
   localparam int unsigned CW = slob_pkg::CNT_W;

   slob_pkg::state_type state_ff, state_in;
   logic [2:0]          op_ff, op_in;
   logic                side_ff, side_in;
   slob_pkg::entry_type cur_ff, cur_in;
   logic [31:0]         tgt_ff, tgt_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                moved_ff, moved_in;
   logic [CW-1:0]       buy_cnt_ff, buy_cnt_in;
   logic [CW-1:0]       sell_cnt_ff, sell_cnt_in;
   logic [31:0]         nid_ff, nid_in;
   logic                silent_ff, silent_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic                rsp_side_ff, rsp_side_in;
   logic                rsp_last_ff, rsp_last_in;
   slob_pkg::entry_type rsp_entry_ff, rsp_entry_in;

   logic                ram_we;
   logic [IW-1:0]       ram_widx;
   logic [IW-1:0]       ram_ridx;
   slob_pkg::entry_type ram_wdata;
   slob_pkg::entry_type ram_rdata;
   logic                out_load;
   logic                cmp_swap;
   logic                ahead;
   slob_pkg::entry_type cmp_a, cmp_b;

   logic                req_fire;
   logic                out_free;
   logic                csr_write;
   logic [CW-1:0]       n_cur;
   logic [CW-1:0]       idx_dec;
   logic [CW-1:0]       idx_inc;
   logic                at_end;
   logic                last_idx;
   logic                idx_zero;
   logic                full;
   logic                match;

   assign req_tready = (state_ff == slob_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == slob_pkg::CSR_SILENT_ADDR) ?
                       {31'd0, silent_ff} : 32'd0;

   assign n_cur    = side_ff ? sell_cnt_ff : buy_cnt_ff;
   assign idx_dec  = idx_ff - CW'(1);
   assign idx_inc  = idx_ff + CW'(1);
   assign at_end   = (idx_ff == n_cur);
   assign last_idx = (idx_inc == n_cur);
   assign idx_zero = (idx_ff == '0);
   assign full     = (n_cur == CW'(slob_pkg::DEPTH));
   assign match    = (ram_rdata.id == tgt_ff);

   // The same ordering unit serves insertion, upward and downward moves;
   // on the downward move the stored neighbor is tested against the order.
   assign cmp_swap = (state_ff == slob_pkg::ST_U_DN_EX);
   assign cmp_a    = cmp_swap ? ram_rdata : cur_ff;
   assign cmp_b    = cmp_swap ? cur_ff : ram_rdata;

   slob_cmp u_cmp (
      .a     (cmp_a),
      .b     (cmp_b),
      .desc  (!side_ff),
      .ahead (ahead)
   );

   // Both sides share one memory; the side is the top address bit.
   slob_ram #(
      .WIDTH (slob_pkg::ENTRY_W),
      .DEPTH (slob_pkg::RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr ({side_ff, ram_widx}),
      .wdata (ram_wdata),
      .raddr ({side_ff, ram_ridx}),
      .rdata (ram_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slob_pkg::ST_IDLE: begin
            if (req_fire) state_in = slob_pkg::ST_DISP;
         end
         slob_pkg::ST_DISP: begin
            case (op_ff)
               slob_pkg::REQ_CREATE: begin
                  state_in = full ? slob_pkg::ST_REJ : slob_pkg::ST_C_RD;
               end
               slob_pkg::REQ_UPDATE, slob_pkg::REQ_REMOVE: begin
                  state_in = slob_pkg::ST_F_RD;
               end
               slob_pkg::REQ_DUMP_BID, slob_pkg::REQ_DUMP_ASK: begin
                  state_in = (silent_ff || n_cur == '0) ? slob_pkg::ST_IDLE :
                             slob_pkg::ST_DP_RD;
               end
               default: state_in = slob_pkg::ST_IDLE;
            endcase
         end
         slob_pkg::ST_REJ: begin
            if (out_free) state_in = slob_pkg::ST_IDLE;
         end
         slob_pkg::ST_C_RD: begin
            state_in = idx_zero ? slob_pkg::ST_IDLE : slob_pkg::ST_C_EX;
         end
         slob_pkg::ST_C_EX: begin
            state_in = ahead ? slob_pkg::ST_C_RD : slob_pkg::ST_IDLE;
         end
         slob_pkg::ST_F_RD: begin
            if (at_end) begin
               state_in = side_ff ? slob_pkg::ST_IDLE : slob_pkg::ST_F_RD;
            end else begin
               state_in = slob_pkg::ST_F_EX;
            end
         end
         slob_pkg::ST_F_EX: begin
            if (match) begin
               state_in = (op_ff == slob_pkg::REQ_UPDATE) ? slob_pkg::ST_U_UP_RD :
                          slob_pkg::ST_R_RD;
            end else begin
               state_in = slob_pkg::ST_F_RD;
            end
         end
         slob_pkg::ST_U_UP_RD: begin
            if (idx_zero) begin
               if (moved_ff) begin
                  state_in = side_ff ? slob_pkg::ST_IDLE : slob_pkg::ST_F_RD;
               end else begin
                  state_in = slob_pkg::ST_U_DN_RD;
               end
            end else begin
               state_in = slob_pkg::ST_U_UP_EX;
            end
         end
         slob_pkg::ST_U_UP_EX: begin
            if (ahead) begin
               state_in = slob_pkg::ST_U_UP_RD;
            end else if (moved_ff) begin
               state_in = side_ff ? slob_pkg::ST_IDLE : slob_pkg::ST_F_RD;
            end else begin
               state_in = slob_pkg::ST_U_DN_RD;
            end
         end
         slob_pkg::ST_U_DN_RD: begin
            if (last_idx) begin
               state_in = side_ff ? slob_pkg::ST_IDLE : slob_pkg::ST_F_RD;
            end else begin
               state_in = slob_pkg::ST_U_DN_EX;
            end
         end
         slob_pkg::ST_U_DN_EX: begin
            if (ahead) begin
               state_in = slob_pkg::ST_U_DN_RD;
            end else begin
               state_in = side_ff ? slob_pkg::ST_IDLE : slob_pkg::ST_F_RD;
            end
         end
         slob_pkg::ST_R_RD: begin
            if (last_idx) begin
               state_in = side_ff ? slob_pkg::ST_IDLE : slob_pkg::ST_F_RD;
            end else begin
               state_in = slob_pkg::ST_R_EX;
            end
         end
         slob_pkg::ST_R_EX: state_in = slob_pkg::ST_R_RD;
         slob_pkg::ST_DP_RD: state_in = slob_pkg::ST_DP_EX;
         slob_pkg::ST_DP_EX: begin
            if (out_free) begin
               state_in = last_idx ? slob_pkg::ST_IDLE : slob_pkg::ST_DP_RD;
            end
         end
         default: state_in = slob_pkg::ST_IDLE;
      endcase
   end

   // Memory and response controls.
   always_comb begin
      ram_we    = 1'b0;
      ram_widx  = idx_ff[IW-1:0];
      ram_wdata = cur_ff;
      ram_ridx  = idx_ff[IW-1:0];
      out_load  = 1'b0;
      case (state_ff)
         slob_pkg::ST_REJ: out_load = out_free;
         slob_pkg::ST_C_RD: begin
            if (idx_zero) begin
               ram_we = 1'b1;
            end else begin
               ram_ridx = idx_dec[IW-1:0];
            end
         end
         slob_pkg::ST_C_EX: begin
            ram_we    = 1'b1;
            ram_wdata = ahead ? ram_rdata : cur_ff;
         end
         slob_pkg::ST_U_UP_RD: begin
            if (idx_zero) begin
               ram_we = moved_ff;
            end else begin
               ram_ridx = idx_dec[IW-1:0];
            end
         end
         slob_pkg::ST_U_UP_EX: begin
            if (ahead) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
            end else begin
               ram_we = moved_ff;
            end
         end
         slob_pkg::ST_U_DN_RD: begin
            if (last_idx) begin
               ram_we = 1'b1;
            end else begin
               ram_ridx = idx_inc[IW-1:0];
            end
         end
         slob_pkg::ST_U_DN_EX: begin
            ram_we    = 1'b1;
            ram_wdata = ahead ? ram_rdata : cur_ff;
         end
         slob_pkg::ST_R_RD: ram_ridx = idx_inc[IW-1:0];
         slob_pkg::ST_R_EX: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
         end
         slob_pkg::ST_DP_EX: out_load = out_free;
         default: ram_we = 1'b0;
      endcase
   end

   // Working registers, counts and the response register.
   always_comb begin
      op_in         = op_ff;
      side_in       = side_ff;
      cur_in        = cur_ff;
      tgt_in        = tgt_ff;
      idx_in        = idx_ff;
      moved_in      = moved_ff;
      buy_cnt_in    = buy_cnt_ff;
      sell_cnt_in   = sell_cnt_ff;
      nid_in        = nid_ff;
      silent_in     = silent_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_side_in   = rsp_side_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_entry_in  = rsp_entry_ff;

      if (csr_write && csr_paddr == slob_pkg::CSR_SILENT_ADDR) begin
         silent_in = csr_pwdata[0];
      end

      case (state_ff)
         slob_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in = req_tuser;
               if (req_tuser == slob_pkg::REQ_DUMP_ASK) begin
                  side_in = 1'b1;
               end else if (req_tuser == slob_pkg::REQ_CREATE) begin
                  side_in = req_tdata[0];
               end else begin
                  side_in = 1'b0;
               end
               cur_in.id    = nid_ff;
               cur_in.price = req_tdata[32:1];
               cur_in.qty   = req_tdata[64:33];
               tgt_in       = req_tdata[96:65];
            end
         end
         slob_pkg::ST_DISP: begin
            idx_in = '0;
            if (op_ff == slob_pkg::REQ_CREATE) begin
               nid_in = nid_ff + 32'd1;
               if (!full) begin
                  // The new order starts at the tail and sinks toward the head.
                  idx_in = n_cur;
                  if (side_ff) sell_cnt_in = sell_cnt_ff + CW'(1);
                  else         buy_cnt_in  = buy_cnt_ff + CW'(1);
               end
            end
         end
         slob_pkg::ST_C_EX: begin
            if (ahead) idx_in = idx_dec;
         end
         slob_pkg::ST_F_RD: begin
            if (at_end && !side_ff) begin
               side_in = 1'b1;
               idx_in  = '0;
            end
         end
         slob_pkg::ST_F_EX: begin
            if (match) begin
               moved_in = 1'b0;
               if (op_ff == slob_pkg::REQ_UPDATE) begin
                  cur_in.id  = ram_rdata.id;
                  cur_in.qty = ram_rdata.qty;
               end
            end else begin
               idx_in = idx_inc;
            end
         end
         slob_pkg::ST_U_UP_RD: begin
            if (idx_zero && moved_ff && !side_ff) begin
               side_in = 1'b1;
               idx_in  = '0;
            end
         end
         slob_pkg::ST_U_UP_EX: begin
            if (ahead) begin
               idx_in   = idx_dec;
               moved_in = 1'b1;
            end else if (moved_ff && !side_ff) begin
               side_in = 1'b1;
               idx_in  = '0;
            end
         end
         slob_pkg::ST_U_DN_RD: begin
            if (last_idx && !side_ff) begin
               side_in = 1'b1;
               idx_in  = '0;
            end
         end
         slob_pkg::ST_U_DN_EX: begin
            if (ahead) begin
               idx_in = idx_inc;
            end else if (!side_ff) begin
               side_in = 1'b1;
               idx_in  = '0;
            end
         end
         slob_pkg::ST_R_RD: begin
            if (last_idx) begin
               if (side_ff) sell_cnt_in = sell_cnt_ff - CW'(1);
               else         buy_cnt_in  = buy_cnt_ff - CW'(1);
               if (!side_ff) begin
                  side_in = 1'b1;
                  idx_in  = '0;
               end
            end
         end
         slob_pkg::ST_R_EX: idx_in = idx_inc;
         slob_pkg::ST_DP_EX: begin
            if (out_free && !last_idx) idx_in = idx_inc;
         end
         default: idx_in = idx_ff;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_side_in  = side_ff;
         if (state_ff == slob_pkg::ST_REJ) begin
            rsp_status_in = slob_pkg::STATUS_FULL;
            rsp_entry_in  = cur_ff;
            rsp_last_in   = 1'b1;
         end else begin
            rsp_status_in = slob_pkg::STATUS_ENTRY;
            rsp_entry_in  = ram_rdata;
            rsp_last_in   = last_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slob_pkg::ST_IDLE;
         buy_cnt_ff   <= '0;
         sell_cnt_ff  <= '0;
         nid_ff       <= '0;
         silent_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buy_cnt_ff   <= buy_cnt_in;
         sell_cnt_ff  <= sell_cnt_in;
         nid_ff       <= nid_in;
         silent_ff    <= silent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      side_ff       <= side_in;
      cur_ff        <= cur_in;
      tgt_ff        <= tgt_in;
      idx_ff        <= idx_in;
      moved_ff      <= moved_in;
      rsp_status_ff <= rsp_status_in;
      rsp_side_ff   <= rsp_side_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_entry_ff.qty, rsp_entry_ff.price, rsp_side_ff,
                        rsp_entry_ff.id};

endmodule

/* rtl/slob_checker.sv */
`timescale 1ns / 1ps
`include "sorted_limit_order_book_unit_macros.svh"
module slob_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [0:0] rsp_tuser,
   input logic       rsp_tlast
);

   `SLOB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "response dropped while stalled")
   `SLOB_ASSERT(a_busy_after_req, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while busy")
   `SLOB_ASSERT(a_full_is_last, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tlast, "rejected create not marked last")
   `SLOB_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

bind sorted_limit_order_book_unit slob_checker u_slob_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

/* tb/sorted_limit_order_book_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the two-sided sorted order list.
// A directed table runs first, then random traffic biased toward live ids.
// Every accepted request goes through a local model of both lists, and the
// expected responses queue up and are compared in order with what leaves rsp_.
module sorted_limit_order_book_unit_tb;

   localparam int LIMIT_CYCLES = 2000000;

   // Request codes the block does not use.
   localparam logic [2:0] REQ_SPARE_A = 3'd5;
   localparam logic [2:0] REQ_SPARE_B = 3'd6;
   localparam logic [2:0] REQ_SPARE_C = 3'd7;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [slob_pkg::TDATA_W-1:0]  req_tdata = '0;
   logic [2:0]                    req_tuser = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [slob_pkg::TDATA_W-1:0]  rsp_tdata;
   logic [0:0]                    rsp_tuser;
   logic                          rsp_tlast;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [slob_pkg::CSR_AW-1:0]   csr_paddr = '0;
   logic [31:0]                   csr_pwdata = '0;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   sorted_limit_order_book_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // One response as the bench expects to see it.
   typedef struct {
      logic        status;
      logic [31:0] id;
      logic        side;
      logic [31:0] price;
      logic [31:0] qty;
      logic        last;
   } book_reply_type;

   // A request row; has_fixed marks rows whose single reply is typed in.
   typedef struct {
      logic [2:0]     kind;
      logic           side;
      logic [31:0]    price;
      logic [31:0]    qty;
      logic [31:0]    id;
      bit             has_fixed;
      book_reply_type fixed;
   } book_request_type;

   // Local copy of both lists; index 0 is buy, 1 is sell.
   logic [31:0] mdl_id  [2][slob_pkg::DEPTH];
   logic [31:0] mdl_prc [2][slob_pkg::DEPTH];
   logic [31:0] mdl_qty [2][slob_pkg::DEPTH];
   int          mdl_cnt [2];
   logic [31:0] mdl_next_id;
   logic        mdl_silent;

   book_reply_type pending_replies[$];
   int             mismatches = 0;
   int             cycle_count = 0;
   bit             idle_off = 1'b0;

   // True when entry a must stand strictly ahead of entry b on side s.
   function automatic bit ranks_ahead(int s, int a, int b);
      if (s == 0)
         return mdl_prc[s][a] > mdl_prc[s][b] ||
                (mdl_prc[s][a] == mdl_prc[s][b] && mdl_qty[s][a] > mdl_qty[s][b]);
      return mdl_prc[s][a] < mdl_prc[s][b] ||
             (mdl_prc[s][a] == mdl_prc[s][b] && mdl_qty[s][a] < mdl_qty[s][b]);
   endfunction

   function automatic void swap_slots(int s, int a, int b);
      logic [31:0] t;
      t = mdl_id[s][a];  mdl_id[s][a]  = mdl_id[s][b];  mdl_id[s][b]  = t;
      t = mdl_prc[s][a]; mdl_prc[s][a] = mdl_prc[s][b]; mdl_prc[s][b] = t;
      t = mdl_qty[s][a]; mdl_qty[s][a] = mdl_qty[s][b]; mdl_qty[s][b] = t;
   endfunction

   function automatic int find_slot(int s, logic [31:0] id);
      for (int i = 0; i < mdl_cnt[s]; i++)
         if (mdl_id[s][i] == id) return i;
      return -1;
   endfunction

   // Applies one request to the model and queues the replies it causes.
   function automatic void apply_book_request(book_request_type r);
      book_reply_type rep;
      int s, k;
      case (r.kind)
         slob_pkg::REQ_CREATE: begin
            s = r.side;
            if (mdl_cnt[s] >= slob_pkg::DEPTH) begin
               rep = '{slob_pkg::STATUS_FULL, mdl_next_id, r.side, r.price, r.qty, 1'b1};
               pending_replies.push_back(rep);
            end else begin
               k = mdl_cnt[s];
               mdl_id[s][k] = mdl_next_id;
               mdl_prc[s][k] = r.price;
               mdl_qty[s][k] = r.qty;
               mdl_cnt[s]++;
               while (k > 0 && ranks_ahead(s, k, k - 1)) begin
                  swap_slots(s, k, k - 1);
                  k--;
               end
            end
            mdl_next_id = mdl_next_id + 32'd1;
         end
         slob_pkg::REQ_UPDATE: begin
            for (s = 0; s < 2; s++) begin
               k = find_slot(s, r.id);
               if (k >= 0) begin
                  mdl_prc[s][k] = r.price;
                  while (k > 0 && ranks_ahead(s, k, k - 1)) begin
                     swap_slots(s, k, k - 1);
                     k--;
                  end
                  while (k + 1 < mdl_cnt[s] && ranks_ahead(s, k + 1, k)) begin
                     swap_slots(s, k, k + 1);
                     k++;
                  end
               end
            end
         end
         slob_pkg::REQ_REMOVE: begin
            for (s = 0; s < 2; s++) begin
               k = find_slot(s, r.id);
               if (k >= 0) begin
                  for (int i = k; i + 1 < mdl_cnt[s]; i++) begin
                     mdl_id[s][i]  = mdl_id[s][i + 1];
                     mdl_prc[s][i] = mdl_prc[s][i + 1];
                     mdl_qty[s][i] = mdl_qty[s][i + 1];
                  end
                  mdl_cnt[s]--;
               end
            end
         end
         slob_pkg::REQ_DUMP_BID, slob_pkg::REQ_DUMP_ASK: begin
            s = (r.kind == slob_pkg::REQ_DUMP_BID) ? 0 : 1;
            if (!mdl_silent)
               for (int i = 0; i < mdl_cnt[s]; i++) begin
                  rep = '{slob_pkg::STATUS_ENTRY, mdl_id[s][i], s[0], mdl_prc[s][i],
                          mdl_qty[s][i], (i + 1 == mdl_cnt[s])};
                  pending_replies.push_back(rep);
               end
         end
         default: ;
      endcase
   endfunction

   // Drops valid for a random number of cycles now and then.
   task automatic idle_burst();
      if (!idle_off && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(13, 1)) @(negedge clock);
      end
   endtask

   // Drives one request and waits for its handshake; valid stays up so the
   // next request can follow without a gap.
   task automatic send_book_request(book_request_type r);
      idle_burst();
      req_tuser  <= r.kind;
      req_tdata  <= {7'd0, r.id, r.qty, r.price, r.side};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (r.has_fixed) pending_replies.push_back(r.fixed);
      else apply_book_request(r);
      if (r.has_fixed) begin
         // Keep the model in step; drop the duplicate it queues.
         apply_book_request(r);
         void'(pending_replies.pop_back());
      end
      @(negedge clock);
   endtask

   task automatic write_silent(logic [31:0] v);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= slob_pkg::CSR_SILENT_ADDR;
      csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      mdl_silent = v[0];
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // Stops requests, waits until every queued reply has come back, then lets
   // the block settle.
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   function automatic book_request_type mk(logic [2:0] k, logic sd, logic [31:0] p,
                                           logic [31:0] q, logic [31:0] id);
      book_request_type r;
      r = '{k, sd, p, q, id, 1'b0, '{1'b0, '0, 1'b0, '0, '0, 1'b0}};
      return r;
   endfunction

   // Picks an id that is most likely live in one of the lists.
   function automatic logic [31:0] pick_id();
      int s;
      s = $urandom_range(1);
      if ($urandom_range(4) != 0 && mdl_cnt[s] > 0)
         return mdl_id[s][$urandom_range(mdl_cnt[s] - 1)];
      return $urandom();
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom_range(7);
         1: return 32'hFFFF_FFFF - $urandom_range(3);
         default: return $urandom();
      endcase
   endfunction

   // Response side: random stalls.
   initial begin
      forever begin
         @(negedge clock);
         if (!idle_off && $urandom_range(5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(13, 1)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Compares each response with the oldest expectation.
   always @(posedge clock) begin
      book_reply_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            e = pending_replies.pop_front();
            if (rsp_tuser[0] !== e.status || rsp_tdata[31:0] !== e.id ||
                rsp_tdata[32] !== e.side || rsp_tdata[64:33] !== e.price ||
                rsp_tdata[96:65] !== e.qty || rsp_tlast !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st%0d id%h sd%0d p%h q%h l%0d, got st%0d id%h sd%0d p%h q%h l%0d",
                           e.status, e.id, e.side, e.price, e.qty, e.last,
                           rsp_tuser[0], rsp_tdata[31:0], rsp_tdata[32],
                           rsp_tdata[64:33], rsp_tdata[96:65], rsp_tlast);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      book_request_type table_rows[$];
      book_request_type r;
      logic [2:0] k;
      mdl_cnt = '{0, 0};
      mdl_next_id = '0;
      mdl_silent = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. Dumps of an empty book return nothing.
      table_rows.push_back(mk(slob_pkg::REQ_DUMP_BID, 1'b0, 0, 0, 0));
      table_rows.push_back(mk(slob_pkg::REQ_DUMP_ASK, 1'b1, 0, 0, 0));
      table_rows.push_back(mk(slob_pkg::REQ_CREATE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
      table_rows.push_back(mk(slob_pkg::REQ_CREATE, 1'b0, 0, 0, 32'hFFFF_FFFF));
      table_rows.push_back(mk(slob_pkg::REQ_CREATE, 1'b0, 100, 5, 0));
      table_rows.push_back(mk(slob_pkg::REQ_CREATE, 1'b0, 100, 5, 0));   // equal keys stay in order
      table_rows.push_back(mk(slob_pkg::REQ_CREATE, 1'b0, 100, 9, 0));
      table_rows.push_back(mk(slob_pkg::REQ_CREATE, 1'b1, 32'hFFFF_FFFF, 0, 0));
      table_rows.push_back(mk(slob_pkg::REQ_CREATE, 1'b1, 0, 32'hFFFF_FFFF, 0));
      table_rows.push_back(mk(slob_pkg::REQ_CREATE, 1'b1, 50, 2, 0));
      table_rows.push_back(mk(slob_pkg::REQ_DUMP_BID, 1'b0, 0, 0, 0));
      table_rows.push_back(mk(slob_pkg::REQ_DUMP_ASK, 1'b0, 0, 0, 0));
      table_rows.push_back(mk(slob_pkg::REQ_UPDATE, 1'b0, 32'hFFFF_FFFF, 0, 4));
      table_rows.push_back(mk(slob_pkg::REQ_UPDATE, 1'b0, 0, 0, 7));
      table_rows.push_back(mk(slob_pkg::REQ_UPDATE, 1'b0, 1, 0, 32'h1234_5678)); // unknown id
      table_rows.push_back(mk(slob_pkg::REQ_REMOVE, 1'b0, 0, 0, 0));
      table_rows.push_back(mk(slob_pkg::REQ_REMOVE, 1'b0, 0, 0, 32'hDEAD_BEEF)); // unknown id
      table_rows.push_back(mk(REQ_SPARE_A, 1'b1, 1, 1, 1));                    // unused codes
      table_rows.push_back(mk(REQ_SPARE_B, 1'b0, 1, 1, 1));
      table_rows.push_back(mk(REQ_SPARE_C, 1'b1, 1, 1, 1));
      table_rows.push_back(mk(slob_pkg::REQ_DUMP_BID, 1'b0, 0, 0, 0));
      table_rows.push_back(mk(slob_pkg::REQ_DUMP_ASK, 1'b0, 0, 0, 0));
      foreach (table_rows[i]) send_book_request(table_rows[i]);
      drain_replies();

      // Silent mode hides dumps.
      write_silent(32'd1);
      send_book_request(mk(slob_pkg::REQ_DUMP_BID, 1'b0, 0, 0, 0));
      send_book_request(mk(slob_pkg::REQ_DUMP_ASK, 1'b0, 0, 0, 0));
      drain_replies();
      write_silent(32'd0);

      // Fill the sell side and overflow it; the reject reply is known up front.
      while (mdl_cnt[1] < slob_pkg::DEPTH)
         send_book_request(mk(slob_pkg::REQ_CREATE, 1'b1, $urandom_range(20),
                              $urandom_range(3), 0));
      r = mk(slob_pkg::REQ_CREATE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      r.has_fixed = 1'b1;
      r.fixed = '{slob_pkg::STATUS_FULL, mdl_next_id, 1'b1, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 1'b1};
      send_book_request(r);
      send_book_request(mk(slob_pkg::REQ_DUMP_ASK, 1'b0, 0, 0, 0));
      drain_replies();

      // Random traffic; the middle part runs with a random silent setting and the tail has no idling.
      for (int n = 0; n < 205; n++) begin
         if (n == 100) begin
            drain_replies();
            write_silent($urandom_range(1));
         end
         if (n == 160) begin
            drain_replies();
            write_silent(32'd0);
            idle_off = 1'b1;
         end
         case ($urandom_range(9))
            0, 1, 2, 3: k = slob_pkg::REQ_CREATE;
            4, 5: k = slob_pkg::REQ_UPDATE;
            6, 7: k = slob_pkg::REQ_REMOVE;
            8: k = $urandom_range(1) ? slob_pkg::REQ_DUMP_BID : slob_pkg::REQ_DUMP_ASK;
            default: k = 3'($urandom_range(7));
         endcase
         send_book_request(mk(k, 1'($urandom_range(1)), pick_value(), pick_value(),
                              pick_id()));
      end
      drain_replies();

      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl
rtl/slob_pkg.sv
rtl/slob_ram.sv
rtl/slob_cmp.sv
rtl/sorted_limit_order_book_unit.sv
rtl/slob_checker.sv
tb/sorted_limit_order_book_unit_tb.sv
